FILE: rtl/core/mst_kth_largest_edge_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef MST_KTH_LARGEST_EDGE_DEFINES_SVH
`define MST_KTH_LARGEST_EDGE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MKE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MKE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/mke_pkg.sv
`default_nettype none
package mke_pkg;
   localparam int COORD_W        = 16;
   localparam int SQ_W           = 32;
   localparam int DIST_W         = 33;
   localparam int RANK_W         = 10;
   localparam int ROOT_W         = 25;
   localparam int EC_W           = 9;
   localparam int FRAC_SHIFT     = 16;   // two bits of radicand per fraction bit
   localparam int RAD_W          = 50;
   localparam int DEF_MAX_POINTS = 512;
   localparam int REQ_DATA_W     = 32;
   localparam int RSP_DATA_W     = 72;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [DIST_W-1:0] DIST_INF   = '1;
   localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

   // command codes carried on req_tuser
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   // register index
   localparam logic REG_RANK_S = 1'b0;

   // strobes to the point cells
   typedef struct packed {
      logic load_shift;
      logic init;
      logic sq_en;
      logic upd_en;
      logic load_carry;
      logic shift_carry;
      logic pick;
   } pcell_ctl_type;

   // strobes to the rank cells
   typedef struct packed {
      logic clear;
      logic insert;
      logic shift_out;
   } rcell_ctl_type;

   // candidate that travels down the min chain
   typedef struct packed {
      logic [DIST_W-1:0]  weight;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } cand_type;
endpackage
`default_nettype wire

FILE: rtl/core/mst_kth_largest_edge.sv
// Rank-selected edge of the Euclidean minimum spanning tree of up to MAX_POINTS loaded
// points. Load beats (tuser 0) are taken one per cycle while idle and shift into a chain
// of point cells; loads past capacity are dropped and flagged. A compute beat (tuser 1)
// stalls req_tready while Prim's method runs on the chain: per tree edge the cells square
// and then update their distances, the min chain is seeded, the minimum ripples down
// the chain past each loaded point, and a pick step adds it to the tree. Edge
// weights are insertion-sorted into a rank chain as they appear; for a rank in range,
// rank_s - 1 shifts then bring the selected edge to its head, and a bit-serial
// square root follows. One response beat is then issued, the point set and overflow flag
// are cleared, and loads are accepted while that beat waits.
`default_nettype none
`include "mst_kth_largest_edge_defines.svh"
module mst_kth_largest_edge import mke_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // x_coord[15:0], y_coord[31:16]
   input  logic                  req_tuser,   // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // length_squared[32:0], length_fixed[57:33], edge_count[66:58], point_overflow[67]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int CMP_W = (RANK_W > CNT_W) ? RANK_W : CNT_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_SQ, S_UPD, S_LDC, S_SCAN, S_PICK,
      S_SEL, S_SHIFT, S_START, S_ROOT, S_OUT
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   count_ff, edges_ff, k_ff, scan_ff;
   logic               ovf_ff, zero_ff;
   logic [RANK_W-1:0]  rank_ff, shift_ff;
   logic [COORD_W-1:0] pick_x_ff, pick_y_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [DIST_W-1:0]  sel_ff;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic req_acc, out_go, rank_bad, sq_done;
   logic [DIST_W-1:0]  sq_value;
   logic [ROOT_W-1:0]  sq_root;
   pcell_ctl_type      pctl;
   rcell_ctl_type      rctl;

   logic [COORD_W-1:0] x_arr [MAX_POINTS];
   logic [COORD_W-1:0] y_arr [MAX_POINTS];
   cand_type           carry_arr [MAX_POINTS];
   logic [IDX_W-1:0]   cidx_arr [MAX_POINTS];
   logic [DIST_W-1:0]  rval_arr [MAX_POINTS];
   logic               rvalid_arr [MAX_POINTS];

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_go     = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign rank_bad   = (rank_ff == '0) || (CMP_W'(rank_ff) > CMP_W'(edges_ff));
   assign sq_value   = zero_ff ? '0 : rval_arr[0];

   // cell strobes
   always_comb begin
      pctl.load_shift  = req_acc && (req_tuser == CMD_LOAD) && (count_ff < CNT_MAX);
      pctl.init        = (state_ff == S_INIT);
      pctl.sq_en       = (state_ff == S_SQ);
      pctl.upd_en      = (state_ff == S_UPD);
      pctl.load_carry  = (state_ff == S_LDC);
      pctl.shift_carry = (state_ff == S_SCAN);
      pctl.pick        = (state_ff == S_PICK);
      rctl.clear       = req_acc && (req_tuser == CMD_COMPUTE);
      rctl.insert      = (state_ff == S_PICK);
      rctl.shift_out   = (state_ff == S_SHIFT);
   end

   // point chain: loads enter at cell 0, the minimum ripples toward cell 0
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_pc
      logic [COORD_W-1:0] xi, yi;
      cand_type           ci;
      logic [IDX_W-1:0]   ii;
      logic               act;
      if (i == 0) begin : g_first
         assign xi = req_tdata[COORD_W-1:0];
         assign yi = req_tdata[2*COORD_W-1:COORD_W];
      end else begin : g_mid
         assign xi = x_arr[i-1];
         assign yi = y_arr[i-1];
      end
      if (i == MAX_POINTS - 1) begin : g_last
         assign ci = '{weight: DIST_INF, x: '0, y: '0};
         assign ii = '0;
      end else begin : g_inner
         assign ci = carry_arr[i+1];
         assign ii = cidx_arr[i+1];
      end
      assign act = (CNT_W'(i) < count_ff);
      mke_point_cell #(.IDX_W(IDX_W), .CELL_IDX(i)) u_pc (
         .clock(clock), .ctl(pctl), .active(act),
         .x_in(xi), .y_in(yi), .x_out(x_arr[i]), .y_out(y_arr[i]),
         .pick_x(pick_x_ff), .pick_y(pick_y_ff), .pick_idx(cidx_arr[0]),
         .carry_in(ci), .carry_idx_in(ii),
         .carry_out(carry_arr[i]), .carry_idx_out(cidx_arr[i])
      );
   end

   // rank chain, largest weight at cell 0
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_rc
      logic [DIST_W-1:0] pv, nv;
      logic              pvl, nvl;
      if (i == 0) begin : g_first
         assign pv  = DIST_INF;
         assign pvl = 1'b1;
      end else begin : g_mid
         assign pv  = rval_arr[i-1];
         assign pvl = rvalid_arr[i-1];
      end
      if (i == MAX_POINTS - 1) begin : g_last
         assign nv  = '0;
         assign nvl = 1'b0;
      end else begin : g_inner
         assign nv  = rval_arr[i+1];
         assign nvl = rvalid_arr[i+1];
      end
      mke_rank_cell u_rc (
         .clock(clock), .reset(reset), .ctl(rctl), .w_in(carry_arr[0].weight),
         .prev_val(pv), .prev_valid(pvl), .next_val(nv), .next_valid(nvl),
         .val_out(rval_arr[i]), .valid_out(rvalid_arr[i])
      );
   end

   mke_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(state_ff == S_START),
      .value(sq_value), .done(sq_done), .root(sq_root)
   );

   // sequencer, counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !out_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  if (req_tuser == CMD_LOAD) begin
                     if (count_ff < CNT_MAX) begin
                        count_ff <= count_ff + CNT_W'(1);
                     end else begin
                        ovf_ff <= 1'b1;
                     end
                  end else begin
                     k_ff <= '0;
                     if (count_ff >= CNT_W'(2)) begin
                        edges_ff <= count_ff - CNT_W'(1);
                        state_ff <= S_INIT;
                     end else begin
                        edges_ff <= '0;
                        state_ff <= S_SEL;
                     end
                  end
               end
            end
            S_INIT: begin
               pick_x_ff <= x_arr[0];
               pick_y_ff <= y_arr[0];
               state_ff  <= S_SQ;
            end
            S_SQ: state_ff <= S_UPD;
            S_UPD: state_ff <= (k_ff == edges_ff) ? S_SEL : S_LDC;
            S_LDC: begin
               scan_ff  <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               scan_ff <= scan_ff + CNT_W'(1);
               if (scan_ff == count_ff - CNT_W'(1)) begin
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               pick_x_ff <= carry_arr[0].x;
               pick_y_ff <= carry_arr[0].y;
               k_ff      <= k_ff + CNT_W'(1);
               state_ff  <= S_SQ;
            end
            S_SEL: begin
               zero_ff  <= rank_bad;
               shift_ff <= rank_ff - RANK_W'(1);
               state_ff <= (rank_bad || (rank_ff == RANK_W'(1))) ? S_START : S_SHIFT;
            end
            S_SHIFT: begin
               shift_ff <= shift_ff - RANK_W'(1);
               if (shift_ff == RANK_W'(1)) begin
                  state_ff <= S_START;
               end
            end
            S_START: begin
               sel_ff   <= sq_value;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               if (sq_done) begin
                  root_ff  <= sq_root;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= RSP_DATA_W'({ovf_ff, EC_W'(edges_ff), root_ff, sel_ff});
                  count_ff     <= '0;
                  ovf_ff       <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_RANK_S)) begin
         rank_ff <= csr_pwdata[RANK_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_RANK_S) ? CSR_DATA_W'(rank_ff) : '0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MKE_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_MAX, "point count over capacity")
   `MKE_ASSERT_NEXT(a_busy_after_compute, clock, reset, req_acc && (req_tuser == CMD_COMPUTE), !req_tready, "compute beat did not stall input")
   `MKE_ASSERT_NEXT(a_clear_after_report, clock, reset, out_go, (count_ff == '0) && !ovf_ff && rsp_tvalid, "point set not cleared on report")
   `MKE_ASSERT_SAME(a_picks_bounded, clock, reset, state_ff != S_IDLE, k_ff <= edges_ff, "more picks than tree edges")
endmodule
`default_nettype wire

FILE: rtl/core/mke_point_cell.sv
`default_nettype none
module mke_point_cell import mke_pkg::*; #(
   parameter int IDX_W    = 9,
   parameter int CELL_IDX = 0
) (
   input  logic               clock,
   input  pcell_ctl_type      ctl,
   input  logic               active,
   input  logic [COORD_W-1:0] x_in,
   input  logic [COORD_W-1:0] y_in,
   output logic [COORD_W-1:0] x_out,
   output logic [COORD_W-1:0] y_out,
   input  logic [COORD_W-1:0] pick_x,
   input  logic [COORD_W-1:0] pick_y,
   input  logic [IDX_W-1:0]   pick_idx,
   input  cand_type           carry_in,
   input  logic [IDX_W-1:0]   carry_idx_in,
   output cand_type           carry_out,
   output logic [IDX_W-1:0]   carry_idx_out
);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [COORD_W-1:0] x_ff, y_ff;
   logic               in_tree_ff;
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   cand_type           carry_ff;
   logic [IDX_W-1:0]   cidx_ff;
   logic [COORD_W-1:0] dx, dy;
   logic [DIST_W-1:0]  dist_sum;

   // distance to the newest tree point
   always_comb begin
      dx       = (x_ff > pick_x) ? (x_ff - pick_x) : (pick_x - x_ff);
      dy       = (y_ff > pick_y) ? (y_ff - pick_y) : (pick_y - y_ff);
      dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      best_in  = best_ff;
      if (ctl.init) begin
         best_in = DIST_INF;
      end else if (ctl.upd_en && (dist_sum < best_ff)) begin
         best_in = dist_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_shift) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (ctl.init) begin
         in_tree_ff <= (CELL_IDX == 0);
      end else if (ctl.pick && (pick_idx == MY_IDX)) begin
         in_tree_ff <= 1'b1;
      end
      if (ctl.sq_en) begin
         sqx_ff <= SQ_W'(dx) * SQ_W'(dx);
         sqy_ff <= SQ_W'(dy) * SQ_W'(dy);
      end
      best_ff <= best_in;
      // min chain: seed with own candidate, then keep the smaller of self and right neighbor
      if (ctl.load_carry) begin
         carry_ff.weight <= (active && !in_tree_ff) ? best_ff : DIST_INF;
         carry_ff.x      <= x_ff;
         carry_ff.y      <= y_ff;
         cidx_ff         <= MY_IDX;
      end else if (ctl.shift_carry && (carry_in.weight < carry_ff.weight)) begin
         carry_ff <= carry_in;
         cidx_ff  <= carry_idx_in;
      end
   end

   assign x_out         = x_ff;
   assign y_out         = y_ff;
   assign carry_out     = carry_ff;
   assign carry_idx_out = cidx_ff;
endmodule
`default_nettype wire

FILE: rtl/core/mke_rank_cell.sv
`default_nettype none
module mke_rank_cell import mke_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  rcell_ctl_type     ctl,
   input  logic [DIST_W-1:0] w_in,
   input  logic [DIST_W-1:0] prev_val,
   input  logic              prev_valid,
   input  logic [DIST_W-1:0] next_val,
   input  logic              next_valid,
   output logic [DIST_W-1:0] val_out,
   output logic              valid_out
);
   logic [DIST_W-1:0] val_ff;
   logic              valid_ff;
   logic              beats_self, fits_here;

   // descending sorted insert: the weight lands where it first beats the held value
   assign beats_self = !valid_ff || (w_in > val_ff);
   assign fits_here  = prev_valid && (w_in <= prev_val);

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift_out) begin
         val_ff   <= next_val;
         valid_ff <= next_valid;
      end else if (ctl.insert && beats_self) begin
         if (fits_here) begin
            val_ff   <= w_in;
            valid_ff <= 1'b1;
         end else if (prev_valid) begin
            val_ff   <= prev_val;
            valid_ff <= 1'b1;
         end
      end
   end

   assign val_out   = val_ff;
   assign valid_out = valid_ff;
endmodule
`default_nettype wire

FILE: rtl/core/mke_sqrt.sv
`default_nettype none
module mke_sqrt import mke_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIST_W-1:0] value,
   output logic              done,
   output logic [ROOT_W-1:0] root
);
   logic [RAD_W-1:0] rem_ff, res_ff, bit_ff, trial;
   logic             run_ff, done_ff;

   assign trial = res_ff + bit_ff;

   // one result bit per cycle, radicand bits taken two at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= RAD_W'({value, {FRAC_SHIFT{1'b0}}});
            res_ff <= '0;
            bit_ff <= RAD_W'(1) << (RAD_W - 2);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff == RAD_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];
endmodule
`default_nettype wire
